// File: rtl/spsub_pkg.sv
// Shared types and default sizes for the stream pattern substitution block.
package spsub_pkg;

  // Default table sizes.
  localparam int NumPatternsDef       = 8;
  localparam int MaxPatternLenDef     = 16;
  localparam int MaxReplacementLenDef = 32;

  // Field widths fixed by the item format.
  localparam int ActionW    = 3;
  localparam int ByteW      = 8;
  localparam int EntryIdxW  = 3;
  localparam int BytePosW   = 5;
  localparam int PatLenInW  = 5;
  localparam int RepLenInW  = 6;
  localparam int PatCountW  = 4;

  typedef enum logic [ActionW-1:0] {
    ACT_DATA  = 3'd0,
    ACT_PAT   = 3'd1,
    ACT_REP   = 3'd2,
    ACT_LEN   = 3'd3,
    ACT_FLUSH = 3'd4
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_TAKE,
    S_REL_RD,
    S_REL_EMIT,
    S_REP_RD,
    S_REP_EMIT,
    S_EMIT_IN
  } state_e;

endpackage

// File: rtl/spsub_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
module spsub_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/stream_pattern_substitute_core.sv
// Stream pattern substitution core: sequencer, length tables and table RAMs.
//
// Input channel (in_valid_i / in_stall_o) carries one item per handshake:
// a stream data byte, a pattern or replacement table byte, a length pair
// for one entry, or a flush. The output channel (out_valid_o / out_stall_i)
// returns the rewritten byte stream, with last_o set on the final byte that
// an item produces; items that produce nothing return nothing.
// pattern_count is to be written through cfg_we_i / cfg_wdata_i while
// idle; the block does not enforce this. It takes one item at a time and
// holds in_stall_o high until it is done. A data byte with no match open
// is searched over the first pattern_count entries, one entry per cycle
// through the shared first-byte compare fed by the pattern RAM, then
// emitted or taken into a match. Each released held byte and each
// replacement byte goes through a registered RAM read, then an output
// load. The output register lets the next item in while the last result
// still waits; a stalled receiver only holds the emit states.
// Reset clears the length tables (all entries disabled), pattern_count and
// the match state; table RAM contents are undefined until written.
module stream_pattern_substitute_core #(
  parameter int NUM_PATTERNS        = spsub_pkg::NumPatternsDef,
  parameter int MAX_PATTERN_LEN     = spsub_pkg::MaxPatternLenDef,
  parameter int MAX_REPLACEMENT_LEN = spsub_pkg::MaxReplacementLenDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spsub_pkg::PatCountW-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [spsub_pkg::ActionW-1:0]    action_i,
  input  logic [spsub_pkg::ByteW-1:0]      data_byte_i,
  input  logic [spsub_pkg::EntryIdxW-1:0]  entry_index_i,
  input  logic [spsub_pkg::BytePosW-1:0]   byte_position_i,
  input  logic [spsub_pkg::PatLenInW-1:0]  pattern_length_i,
  input  logic [spsub_pkg::RepLenInW-1:0]  replacement_length_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [spsub_pkg::ByteW-1:0]      out_byte_o,
  output logic                             last_o
);

  localparam int EW     = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int CW     = $clog2(NUM_PATTERNS + 1);
  localparam int PLW    = $clog2(MAX_PATTERN_LEN + 1);
  localparam int RLW    = $clog2(MAX_REPLACEMENT_LEN + 1);
  localparam int HAW    = $clog2(MAX_PATTERN_LEN);
  localparam int PDEPTH = NUM_PATTERNS * MAX_PATTERN_LEN;
  localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam int RDEPTH = NUM_PATTERNS * MAX_REPLACEMENT_LEN;
  localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int BW     = spsub_pkg::ByteW;

  spsub_pkg::state_e state_q, state_d;

  logic                            matching_q, matching_d;
  logic [EW-1:0]                   match_entry_q, match_entry_d;
  logic [PLW-1:0]                  mc_q, mc_d;
  logic [BW-1:0]                   byte_q, byte_d;
  logic [CW-1:0]                   scan_q, scan_d;
  logic [PLW-1:0]                  best_q, best_d;
  logic                            found_q, found_d;
  logic [PLW-1:0]                  rel_q, rel_d;
  logic                            tail_q, tail_d;
  logic [RLW-1:0]                  rep_q, rep_d;
  logic [spsub_pkg::PatCountW-1:0] pattern_count_q;
  logic [PLW-1:0]                  plen_q [NUM_PATTERNS];
  logic [RLW-1:0]                  rlen_q [NUM_PATTERNS];
  logic                            out_valid_q, out_valid_d;
  logic [BW-1:0]                   out_byte_q, out_byte_d;
  logic                            out_last_q, out_last_d;

  logic            accept, ent_ok, out_free;
  logic [EW-1:0]   widx, len_idx;
  logic [PLW-1:0]  plen_sel, plen_wdata, mc_nxt, rel_nxt;
  logic [RLW-1:0]  rlen_sel, rlen_wdata, rep_nxt;
  logic [CW-1:0]   cnt_lim, scan_nxt;
  logic            scan_hit, scan_more, chk_miss, take_done, rel_more, rep_last;
  logic            len_release, len_we;

  logic            pat_we, pat_re;
  logic [PAW-1:0]  pat_waddr, pat_raddr;
  logic [BW-1:0]   pat_rdata;
  logic            rep_we, rep_re;
  logic [RAW-1:0]  rep_waddr, rep_raddr;
  logic [BW-1:0]   rep_rdata;
  logic            hold_we, hold_re;
  logic [HAW-1:0]  hold_raddr;
  logic [BW-1:0]   hold_rdata;

  // ---------------------------------------------------------------- decode
  assign accept   = in_valid_i && (state_q == spsub_pkg::S_IDLE);
  assign ent_ok   = 32'(entry_index_i) < NUM_PATTERNS;
  assign widx     = EW'(entry_index_i);
  assign out_free = !out_valid_q || !out_stall_i;

  assign len_idx  = (state_q == spsub_pkg::S_SCAN) ? scan_q[EW-1:0] : match_entry_q;
  assign plen_sel = plen_q[len_idx];
  assign rlen_sel = rlen_q[len_idx];

  assign cnt_lim  = (32'(pattern_count_q) > NUM_PATTERNS) ? CW'(NUM_PATTERNS)
                                                           : CW'(pattern_count_q);

  // shared first-byte compare, one entry per cycle
  assign scan_hit  = (plen_sel != '0) && (pat_rdata == byte_q) && (plen_sel > best_q);
  assign scan_nxt  = scan_q + CW'(1);
  assign scan_more = scan_nxt < cnt_lim;

  assign chk_miss  = (32'(mc_q) >= 32'(plen_sel)) || (32'(mc_q) >= MAX_PATTERN_LEN) ||
                     (pat_rdata != byte_q);
  assign mc_nxt    = mc_q + PLW'(1);
  assign take_done = mc_nxt >= plen_sel;
  assign rel_nxt   = rel_q + PLW'(1);
  assign rel_more  = rel_nxt < mc_q;
  assign rep_nxt   = rep_q + RLW'(1);
  assign rep_last  = rep_nxt >= rlen_sel;

  assign len_we      = accept && (action_i == spsub_pkg::ACT_LEN) && ent_ok;
  assign len_release = len_we && matching_q && (match_entry_q == widx);

  assign plen_wdata = (32'(pattern_length_i) > MAX_PATTERN_LEN) ? PLW'(MAX_PATTERN_LEN)
                                                                : PLW'(pattern_length_i);
  assign rlen_wdata = (32'(replacement_length_i) > MAX_REPLACEMENT_LEN)
                      ? RLW'(MAX_REPLACEMENT_LEN) : RLW'(replacement_length_i);

  // table writes happen in the accept cycle
  assign pat_we    = accept && (action_i == spsub_pkg::ACT_PAT) && ent_ok &&
                     (32'(byte_position_i) < MAX_PATTERN_LEN);
  assign pat_waddr = PAW'(widx) * PAW'(MAX_PATTERN_LEN) + PAW'(byte_position_i);
  assign rep_we    = accept && (action_i == spsub_pkg::ACT_REP) && ent_ok &&
                     (32'(byte_position_i) < MAX_REPLACEMENT_LEN);
  assign rep_waddr = RAW'(widx) * RAW'(MAX_REPLACEMENT_LEN) + RAW'(byte_position_i);
  assign rep_re    = (state_q == spsub_pkg::S_REP_RD);
  assign rep_raddr = RAW'(match_entry_q) * RAW'(MAX_REPLACEMENT_LEN) + RAW'(rep_q);
  assign hold_we    = (state_q == spsub_pkg::S_TAKE);
  assign hold_re    = (state_q == spsub_pkg::S_REL_RD);
  assign hold_raddr = rel_q[HAW-1:0];

  // ------------------------------------------------------------ next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spsub_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (action_i)
            spsub_pkg::ACT_DATA: begin
              if (matching_q) begin
                state_d = spsub_pkg::S_CHECK;
              end else if (cnt_lim != '0) begin
                state_d = spsub_pkg::S_SCAN;
              end else begin
                state_d = spsub_pkg::S_EMIT_IN;
              end
            end
            spsub_pkg::ACT_LEN: begin
              if (len_release) begin
                state_d = spsub_pkg::S_REL_RD;
              end
            end
            spsub_pkg::ACT_FLUSH: begin
              if (matching_q) begin
                state_d = spsub_pkg::S_REL_RD;
              end
            end
            default: state_d = spsub_pkg::S_IDLE;
          endcase
        end
      end
      spsub_pkg::S_SCAN: begin
        if (!scan_more) begin
          state_d = (found_q || scan_hit) ? spsub_pkg::S_TAKE : spsub_pkg::S_EMIT_IN;
        end
      end
      spsub_pkg::S_CHECK: begin
        state_d = chk_miss ? spsub_pkg::S_REL_RD : spsub_pkg::S_TAKE;
      end
      spsub_pkg::S_TAKE: begin
        if (take_done && (rlen_sel != '0)) begin
          state_d = spsub_pkg::S_REP_RD;
        end else begin
          state_d = spsub_pkg::S_IDLE;
        end
      end
      spsub_pkg::S_REL_RD: state_d = spsub_pkg::S_REL_EMIT;
      spsub_pkg::S_REL_EMIT: begin
        if (out_free) begin
          if (rel_more) begin
            state_d = spsub_pkg::S_REL_RD;
          end else begin
            state_d = tail_q ? spsub_pkg::S_EMIT_IN : spsub_pkg::S_IDLE;
          end
        end
      end
      spsub_pkg::S_REP_RD: state_d = spsub_pkg::S_REP_EMIT;
      spsub_pkg::S_REP_EMIT: begin
        if (out_free) begin
          state_d = rep_last ? spsub_pkg::S_IDLE : spsub_pkg::S_REP_RD;
        end
      end
      spsub_pkg::S_EMIT_IN: begin
        if (out_free) begin
          state_d = spsub_pkg::S_IDLE;
        end
      end
      default: state_d = spsub_pkg::S_IDLE;
    endcase
  end

  // -------------------------------------------------------------- datapath
  always_comb begin
    matching_d    = matching_q;
    match_entry_d = match_entry_q;
    mc_d          = mc_q;
    byte_d        = byte_q;
    scan_d        = scan_q;
    best_d        = best_q;
    found_d       = found_q;
    rel_d         = rel_q;
    tail_d        = tail_q;
    rep_d         = rep_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_byte_d    = out_byte_q;
    out_last_d    = out_last_q;
    pat_re        = 1'b0;
    pat_raddr     = '0;

    unique case (state_q)
      spsub_pkg::S_IDLE: begin
        if (accept) begin
          byte_d  = data_byte_i;
          scan_d  = '0;
          best_d  = '0;
          found_d = 1'b0;
          rel_d   = '0;
          tail_d  = 1'b0;
          if (action_i == spsub_pkg::ACT_DATA) begin
            pat_re = 1'b1;
            // open match: next pattern byte; otherwise first byte of entry 0
            if (matching_q) begin
              pat_raddr = PAW'(match_entry_q) * PAW'(MAX_PATTERN_LEN) + PAW'(mc_q);
            end
          end
        end
      end
      spsub_pkg::S_SCAN: begin
        if (scan_hit) begin
          best_d        = plen_sel;
          found_d       = 1'b1;
          match_entry_d = scan_q[EW-1:0];
        end
        scan_d = scan_nxt;
        if (scan_more) begin
          pat_re    = 1'b1;
          pat_raddr = PAW'(scan_nxt[EW-1:0]) * PAW'(MAX_PATTERN_LEN);
        end else begin
          mc_d = '0;
        end
      end
      spsub_pkg::S_CHECK: begin
        tail_d = chk_miss;
      end
      spsub_pkg::S_TAKE: begin
        rep_d = '0;
        if (take_done) begin
          matching_d = 1'b0;
          mc_d       = '0;
        end else begin
          matching_d = 1'b1;
          mc_d       = mc_nxt;
        end
      end
      spsub_pkg::S_REL_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = hold_rdata;
          out_last_d  = !rel_more && !tail_q;
          rel_d       = rel_nxt;
          if (!rel_more) begin
            matching_d = 1'b0;
            mc_d       = '0;
          end
        end
      end
      spsub_pkg::S_REP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = rep_rdata;
          out_last_d  = rep_last;
          rep_d       = rep_nxt;
        end
      end
      spsub_pkg::S_EMIT_IN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = byte_q;
          out_last_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= spsub_pkg::S_IDLE;
      matching_q      <= 1'b0;
      match_entry_q   <= '0;
      mc_q            <= '0;
      scan_q          <= '0;
      best_q          <= '0;
      found_q         <= 1'b0;
      rel_q           <= '0;
      tail_q          <= 1'b0;
      rep_q           <= '0;
      out_valid_q     <= 1'b0;
      pattern_count_q <= '0;
    end else begin
      state_q       <= state_d;
      matching_q    <= matching_d;
      match_entry_q <= match_entry_d;
      mc_q          <= mc_d;
      scan_q        <= scan_d;
      best_q        <= best_d;
      found_q       <= found_d;
      rel_q         <= rel_d;
      tail_q        <= tail_d;
      rep_q         <= rep_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        pattern_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        plen_q[i] <= '0;
        rlen_q[i] <= '0;
      end
    end else if (len_we) begin
      plen_q[widx] <= plen_wdata;
      rlen_q[widx] <= rlen_wdata;
    end
  end

  // ------------------------------------------------------------------ RAMs
  spsub_ram #(
    .WIDTH (BW),
    .DEPTH (PDEPTH),
    .AW    (PAW)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_waddr),
    .wdata_i (data_byte_i),
    .re_i    (pat_re),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  spsub_ram #(
    .WIDTH (BW),
    .DEPTH (RDEPTH),
    .AW    (RAW)
  ) u_rep_ram (
    .clk_i   (clk_i),
    .we_i    (rep_we),
    .waddr_i (rep_waddr),
    .wdata_i (data_byte_i),
    .re_i    (rep_re),
    .raddr_i (rep_raddr),
    .rdata_o (rep_rdata)
  );

  // bytes of the open match, as they arrived
  spsub_ram #(
    .WIDTH (BW),
    .DEPTH (MAX_PATTERN_LEN),
    .AW    (HAW)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (hold_we),
    .waddr_i (mc_q[HAW-1:0]),
    .wdata_i (byte_q),
    .re_i    (hold_re),
    .raddr_i (hold_raddr),
    .rdata_o (hold_rdata)
  );

  assign in_stall_o  = (state_q != spsub_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;

endmodule

// File: tb/spsub_stream_checker.sv
`timescale 1ns / 100ps
// Output stream checker for the pattern substitution core: mirrors the tables and compares.
module spsub_stream_checker
  import spsub_pkg::*;
#(
  parameter int NUM_PATTERNS        = NumPatternsDef,
  parameter int MAX_PATTERN_LEN     = MaxPatternLenDef,
  parameter int MAX_REPLACEMENT_LEN = MaxReplacementLenDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [PatCountW-1:0] cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [ActionW-1:0]   action_i,
  input  logic [ByteW-1:0]     data_byte_i,
  input  logic [EntryIdxW-1:0] entry_index_i,
  input  logic [BytePosW-1:0]  byte_position_i,
  input  logic [PatLenInW-1:0] pattern_length_i,
  input  logic [RepLenInW-1:0] replacement_length_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [ByteW-1:0]     out_byte_i,
  input  logic                 last_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             last;
  } out_byte_t;

  logic [ByteW-1:0] pat_mem [NUM_PATTERNS][MAX_PATTERN_LEN];
  logic [ByteW-1:0] rep_mem [NUM_PATTERNS][MAX_REPLACEMENT_LEN];
  int               pat_len [NUM_PATTERNS];
  int               rep_len [NUM_PATTERNS];
  logic [PatCountW-1:0] pattern_count;
  bit               match_open;
  int               match_entry;
  int               held_count;
  logic [ByteW-1:0] held [MAX_PATTERN_LEN];

  logic [ByteW-1:0] item_bytes [$];
  out_byte_t        expected_stream [$];
  int               mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void release_held();
    if (match_open) begin
      for (int i = 0; i < held_count; i++) item_bytes.push_back(held[i]);
    end
    match_open  = 1'b0;
    match_entry = 0;
    held_count  = 0;
  endfunction

  function automatic void take_data_byte(input logic [ByteW-1:0] b);
    int limit;
    int best;
    int e;
    bit found;
    best  = 0;
    found = 1'b0;
    if (!match_open) begin
      limit = (pattern_count > NUM_PATTERNS) ? NUM_PATTERNS : int'(pattern_count);
      // longest enabled entry wins, strict compare keeps the lowest index on a tie
      for (int i = 0; i < limit; i++) begin
        if (pat_len[i] != 0 && pat_mem[i][0] == b && pat_len[i] > best) begin
          best        = pat_len[i];
          match_entry = i;
          found       = 1'b1;
        end
      end
      if (!found) begin
        item_bytes.push_back(b);
        return;
      end
      match_open = 1'b1;
      held_count = 0;
    end else if (held_count >= pat_len[match_entry] || held_count >= MAX_PATTERN_LEN ||
                 pat_mem[match_entry][held_count] != b) begin
      // mismatching byte goes out after the held ones, no fresh match attempt
      release_held();
      item_bytes.push_back(b);
      return;
    end
    e = match_entry;
    held[held_count] = b;
    held_count++;
    if (held_count >= pat_len[e]) begin
      match_open  = 1'b0;
      match_entry = 0;
      held_count  = 0;
      for (int i = 0; i < rep_len[e]; i++) item_bytes.push_back(rep_mem[e][i]);
    end
  endfunction

  function automatic void rewrite_item();
    out_byte_t r;
    int        e;
    int        pos;
    e   = int'(entry_index_i);
    pos = int'(byte_position_i);
    item_bytes.delete();
    case (action_i)
      ACT_DATA: take_data_byte(data_byte_i);
      ACT_PAT: begin
        if (e < NUM_PATTERNS && pos < MAX_PATTERN_LEN) pat_mem[e][pos] = data_byte_i;
      end
      ACT_REP: begin
        if (e < NUM_PATTERNS && pos < MAX_REPLACEMENT_LEN) rep_mem[e][pos] = data_byte_i;
      end
      ACT_LEN: begin
        if (e < NUM_PATTERNS) begin
          if (match_open && match_entry == e) release_held();
          pat_len[e] = (pattern_length_i > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN :
                       int'(pattern_length_i);
          rep_len[e] = (replacement_length_i > MAX_REPLACEMENT_LEN) ? MAX_REPLACEMENT_LEN :
                       int'(replacement_length_i);
        end
      end
      ACT_FLUSH: release_held();
      default: ;
    endcase
    foreach (item_bytes[i]) begin
      r.value = item_bytes[i];
      r.last  = (i == item_bytes.size() - 1);
      expected_stream.push_back(r);
    end
  endfunction

  task automatic check_result();
    out_byte_t want;
    if (expected_stream.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte_i, last_i));
      return;
    end
    want = expected_stream.pop_front();
    if (out_byte_i !== want.value)
      report_mismatch($sformatf("out_byte %02h, want %02h", out_byte_i, want.value));
    if (last_i !== want.last)
      report_mismatch($sformatf("last %0b on byte %02h, want %0b", last_i, out_byte_i,
                                want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PATTERNS; i++) begin
        pat_len[i] = 0;
        rep_len[i] = 0;
        for (int j = 0; j < MAX_PATTERN_LEN; j++) pat_mem[i][j] = '0;
        for (int j = 0; j < MAX_REPLACEMENT_LEN; j++) rep_mem[i][j] = '0;
      end
      pattern_count = '0;
      match_open    = 1'b0;
      match_entry   = 0;
      held_count    = 0;
      expected_stream.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) rewrite_item();
      if (cfg_we_i) pattern_count = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) check_result();
      pending_o <= expected_stream.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the pattern substitution testbench: clock, reset, stimulus phases and verdict.
module testbench;
  import spsub_pkg::*;

  localparam int NumPhases     = 5;
  localparam int ItemsPerPhase = 45;
  localparam int DrainCycles   = 100;
  localparam logic [ByteW-1:0]   AlphaBase      = 8'h61;
  localparam logic [ActionW-1:0] ActFirstUnused = ActionW'(ACT_FLUSH + 1);
  localparam logic [ActionW-1:0] ActLastUnused  = '1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [PatCountW-1:0] cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [ActionW-1:0]   action_i;
  logic [ByteW-1:0]     data_byte_i;
  logic [EntryIdxW-1:0] entry_index_i;
  logic [BytePosW-1:0]  byte_position_i;
  logic [PatLenInW-1:0] pattern_length_i;
  logic [RepLenInW-1:0] replacement_length_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [ByteW-1:0]     out_byte_o;
  logic                 last_o;
  int                   fail_count;
  int                   pending;

  // what has been loaded, so that only written table bytes are ever compared
  logic [ByteW-1:0] pat_shadow [NumPatternsDef][MaxPatternLenDef];
  bit               pat_known  [NumPatternsDef][MaxPatternLenDef];
  bit               rep_known  [NumPatternsDef][MaxReplacementLenDef];
  int               plen_shadow [NumPatternsDef];
  int               count_shadow;
  int               counted;
  int               gap_pct;
  int               stall_pct;
  int               phase_count [NumPhases] = '{15, 8, 2, 0, 5};
  int               phase_gap   [NumPhases] = '{0, 51, 0, 30, 0};
  int               phase_stall [NumPhases] = '{0, 0, 51, 30, 0};

  stream_pattern_substitute_core i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .action_i,
    .data_byte_i,
    .entry_index_i,
    .byte_position_i,
    .pattern_length_i,
    .replacement_length_i,
    .out_valid_o,
    .out_stall_i,
    .out_byte_o,
    .last_o
  );

  spsub_stream_checker i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_i           (in_stall_o),
    .action_i,
    .data_byte_i,
    .entry_index_i,
    .byte_position_i,
    .pattern_length_i,
    .replacement_length_i,
    .out_valid_i          (out_valid_o),
    .out_stall_i,
    .out_byte_i           (out_byte_o),
    .last_i               (last_o),
    .fail_count_o         (fail_count),
    .pending_o            (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  // small alphabet most of the time so that patterns actually recur in the stream
  function automatic logic [ByteW-1:0] pick_byte();
    if ($urandom_range(3) != 0) return AlphaBase + ByteW'($urandom_range(3));
    return ByteW'($urandom);
  endfunction

  task automatic send_item(input logic [ActionW-1:0] act, input logic [ByteW-1:0] b,
                           input logic [EntryIdxW-1:0] e, input logic [BytePosW-1:0] pos,
                           input logic [PatLenInW-1:0] plen,
                           input logic [RepLenInW-1:0] rlen);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    action_i             <= act;
    data_byte_i          <= b;
    entry_index_i        <= e;
    byte_position_i      <= pos;
    pattern_length_i     <= plen;
    replacement_length_i <= rlen;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    if (act <= ACT_FLUSH && !(act == ACT_PAT && pos >= MaxPatternLenDef)) counted++;
  endtask

  task automatic send_data(input logic [ByteW-1:0] b);
    send_item(ACT_DATA, b, EntryIdxW'($urandom), BytePosW'($urandom), PatLenInW'($urandom),
              RepLenInW'($urandom));
  endtask

  task automatic send_flush();
    send_item(ACT_FLUSH, ByteW'($urandom), EntryIdxW'($urandom), BytePosW'($urandom),
              PatLenInW'($urandom), RepLenInW'($urandom));
  endtask

  task automatic load_pattern_byte(input int e, input int pos, input logic [ByteW-1:0] b);
    send_item(ACT_PAT, b, EntryIdxW'(e), BytePosW'(pos), PatLenInW'($urandom),
              RepLenInW'($urandom));
    if (pos < MaxPatternLenDef) begin
      pat_shadow[e][pos] = b;
      pat_known[e][pos]  = 1'b1;
    end
  endtask

  task automatic load_replacement_byte(input int e, input int pos, input logic [ByteW-1:0] b);
    send_item(ACT_REP, b, EntryIdxW'(e), BytePosW'(pos), PatLenInW'($urandom),
              RepLenInW'($urandom));
    rep_known[e][pos] = 1'b1;
  endtask

  // any byte that the new lengths bring into use is written first
  task automatic set_lengths(input int e, input int plen, input int rlen);
    int pneed;
    int rneed;
    pneed = (plen > MaxPatternLenDef) ? MaxPatternLenDef : plen;
    rneed = (rlen > MaxReplacementLenDef) ? MaxReplacementLenDef : rlen;
    for (int p = 0; p < pneed; p++) begin
      if (!pat_known[e][p]) load_pattern_byte(e, p, pick_byte());
    end
    for (int p = 0; p < rneed; p++) begin
      if (!rep_known[e][p]) load_replacement_byte(e, p, ByteW'($urandom));
    end
    send_item(ACT_LEN, ByteW'($urandom), EntryIdxW'(e), BytePosW'($urandom),
              PatLenInW'(plen), RepLenInW'(rlen));
    plen_shadow[e] = pneed;
  endtask

  task automatic random_load();
    if ($urandom_range(1) == 0) begin
      load_pattern_byte($urandom_range(NumPatternsDef - 1),
                        ($urandom_range(4) != 0) ? $urandom_range(3) : $urandom_range(31),
                        pick_byte());
    end else begin
      load_replacement_byte($urandom_range(NumPatternsDef - 1), $urandom_range(31),
                            ByteW'($urandom));
    end
  endtask

  task automatic random_lengths(input int e);
    int k;
    k = $urandom_range(19);
    if (k < 15) set_lengths(e, $urandom_range(4, 1), $urandom_range(4));
    else if (k < 17) set_lengths(e, 0, $urandom_range(63));
    else set_lengths(e, $urandom_range(31), $urandom_range(63));
  endtask

  // stream one enabled pattern, sometimes cut short, corrupted or disturbed by a table write
  task automatic play_pattern();
    int live [$];
    int lim;
    int e;
    int cut;
    int bad;
    int poke;
    lim = (count_shadow > NumPatternsDef) ? NumPatternsDef : count_shadow;
    for (int i = 0; i < lim; i++) begin
      if (plen_shadow[i] > 0) live.push_back(i);
    end
    if (live.size() == 0) begin
      send_data(pick_byte());
      return;
    end
    e    = live[$urandom_range(live.size() - 1)];
    cut  = plen_shadow[e];
    bad  = -1;
    poke = -1;
    case ($urandom_range(9))
      0, 1: cut = $urandom_range(plen_shadow[e] - 1);
      2, 3: bad = $urandom_range(plen_shadow[e] - 1);
      4:    poke = $urandom_range(plen_shadow[e] - 1);
      default: ;
    endcase
    for (int p = 0; p < cut; p++) begin
      if (p == poke) begin
        if ($urandom_range(1) == 0) random_lengths(e);
        else random_load();
      end
      send_data((p == bad) ? pick_byte() : pat_shadow[e][p]);
    end
    if (cut < plen_shadow[e]) begin
      if ($urandom_range(1) == 0) send_flush();
      else send_data(pick_byte());
    end
  endtask

  task automatic random_item();
    int k;
    k = $urandom_range(99);
    if (k < 50) play_pattern();
    else if (k < 66) send_data(($urandom_range(3) == 0) ? ByteW'($urandom) : pick_byte());
    else if (k < 76) random_load();
    else if (k < 86) random_lengths($urandom_range(NumPatternsDef - 1));
    else if (k < 95) send_flush();
    else send_item(ActionW'($urandom_range(ActLastUnused, ActFirstUnused)), ByteW'($urandom),
                   EntryIdxW'($urandom), BytePosW'($urandom), PatLenInW'($urandom),
                   RepLenInW'($urandom));
  endtask

  // hold the sender until every expected byte is out, optionally letting the core go idle
  task automatic settle(input bit with_tail);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    if (with_tail) repeat (DrainCycles) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_pattern_count(input int value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= PatCountW'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    count_shadow = value;
  endtask

  task automatic directed_items();
    send_data(8'h00);
    send_data(8'hff);
    send_flush();
    send_item(ActFirstUnused, 8'h00, '0, '0, '0, '0);
    send_item(ActLastUnused, 8'hff, '1, '1, '1, '1);
    load_pattern_byte(0, 0, "B");
    load_pattern_byte(0, 1, "D");
    load_replacement_byte(0, 0, 8'h00);
    load_replacement_byte(0, 1, 8'hff);
    set_lengths(0, 2, 2);
    load_pattern_byte(1, 0, "A");
    load_pattern_byte(1, 1, "B");
    load_pattern_byte(1, 2, "C");
    set_lengths(1, 3, 0);
    load_pattern_byte(0, 31, 8'haa);
    // two single-byte entries on the same first byte: the lower index must win
    load_pattern_byte(3, 0, "Q");
    load_replacement_byte(3, 0, "q");
    set_lengths(3, 1, 1);
    load_pattern_byte(5, 0, "Q");
    set_lengths(5, 1, 0);
    send_data("B");
    send_data("D");
    send_data("A");
    send_data("B");
    send_data("C");
    send_data("Q");
    send_data("A");
    send_data("B");
    send_data("A");
    send_data("A");
    send_flush();
    send_data("A");
    send_data("B");
    set_lengths(1, 3, 0);
  endtask

  initial begin
    int target;

    for (int i = 0; i < NumPatternsDef; i++) begin
      plen_shadow[i] = 0;
      for (int j = 0; j < MaxPatternLenDef; j++) pat_known[i][j] = 1'b0;
      for (int j = 0; j < MaxReplacementLenDef; j++) rep_known[i][j] = 1'b0;
    end
    counted   = 0;
    gap_pct   = 0;
    stall_pct = 0;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_wdata_i          <= '0;
    in_valid_i           <= 1'b0;
    action_i             <= ACT_DATA;
    data_byte_i          <= '0;
    entry_index_i        <= '0;
    byte_position_i      <= '0;
    pattern_length_i     <= '0;
    replacement_length_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_pattern_count(phase_count[ph]);
      gap_pct   = phase_gap[ph];
      stall_pct = phase_stall[ph];
      if (ph == 0) directed_items();
      target = counted + ItemsPerPhase;
      while (counted < target) begin
        random_item();
        if (counted >= target - ItemsPerPhase / 2 && counted < target - ItemsPerPhase / 2 + 3)
          settle(1'b0);
      end
      settle(1'b1);
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/spsub_pkg.sv
rtl/spsub_ram.sv
rtl/stream_pattern_substitute_core.sv
tb/spsub_stream_checker.sv
tb/testbench.sv
